// ===== hw/rtl/pocs_pkg.sv =====
package pocs_pkg;

  localparam int LEVEL_W = 18;
  localparam int CODE_W  = 8;
  localparam int OUT_W   = 9;
  localparam int CNT_W   = 13;
  localparam int CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX = 13'd8191;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FINGER_ON  = 3'd0,
    REG_FINGER_OFF = 3'd1,
    REG_RED_HIGH   = 3'd2,
    REG_IR_HIGH    = 3'd3,
    REG_RED_LOW    = 3'd4,
    REG_IR_LOW     = 3'd5,
    REG_HOP        = 3'd6
  } reg_idx_t;

  // Sequencer phases, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_CAL     = 4'b0010,
    PH_COMPUTE = 4'b0100,
    PH_COLLECT = 4'b1000
  } phase_t;

  localparam logic [1:0] PHASE_CODE_IDLE    = 2'd0;
  localparam logic [1:0] PHASE_CODE_CAL     = 2'd1;
  localparam logic [1:0] PHASE_CODE_COMPUTE = 2'd2;
  localparam logic [1:0] PHASE_CODE_COLLECT = 2'd3;

  localparam logic [1:0] LED_NONE = 2'd0;
  localparam logic [1:0] LED_HIGH = 2'd1;
  localparam logic [1:0] LED_LOW  = 2'd2;

  typedef struct packed {
    logic [LEVEL_W-1:0] finger_on_level;
    logic [LEVEL_W-1:0] finger_off_level;
    logic [CODE_W-1:0]  red_current_high;
    logic [CODE_W-1:0]  ir_current_high;
    logic [CODE_W-1:0]  red_current_low;
    logic [CODE_W-1:0]  ir_current_low;
    logic [CODE_W-1:0]  window_hop;
  } cfg_t;

  typedef struct packed {
    logic              finger_on;
    logic              store_en;
    logic [OUT_W-1:0]  write_slot;
    logic [1:0]        phase;
    logic [1:0]        led_cmd;
    logic [CODE_W-1:0] red_current;
    logic [CODE_W-1:0] ir_current;
    logic              window_go;
    logic [OUT_W-1:0]  window_start;
    logic [OUT_W-1:0]  window_length;
  } res_t;

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] code;
    unique case (ph)
      PH_IDLE:    code = PHASE_CODE_IDLE;
      PH_CAL:     code = PHASE_CODE_CAL;
      PH_COMPUTE: code = PHASE_CODE_COMPUTE;
      PH_COLLECT: code = PHASE_CODE_COLLECT;
      default:    code = PHASE_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ===== hw/rtl/pocs_cfg_regs.sv =====
module pocs_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [pocs_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [pocs_pkg::LEVEL_W-1:0]       wr_data,
  output pocs_pkg::cfg_t                     cfg
);

  pocs_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.finger_on_level  <= 18'd50000;
      cfg_r.finger_off_level <= 18'd30000;
      cfg_r.red_current_high <= 8'd36;
      cfg_r.ir_current_high  <= 8'd36;
      cfg_r.red_current_low  <= 8'd2;
      cfg_r.ir_current_low   <= 8'd2;
      cfg_r.window_hop       <= 8'd100;
    end else if (wr_en) begin
      unique case (wr_index)
        pocs_pkg::REG_FINGER_ON:  cfg_r.finger_on_level  <= wr_data;
        pocs_pkg::REG_FINGER_OFF: cfg_r.finger_off_level <= wr_data;
        pocs_pkg::REG_RED_HIGH:   cfg_r.red_current_high <= wr_data[pocs_pkg::CODE_W-1:0];
        pocs_pkg::REG_IR_HIGH:    cfg_r.ir_current_high  <= wr_data[pocs_pkg::CODE_W-1:0];
        pocs_pkg::REG_RED_LOW:    cfg_r.red_current_low  <= wr_data[pocs_pkg::CODE_W-1:0];
        pocs_pkg::REG_IR_LOW:     cfg_r.ir_current_low   <= wr_data[pocs_pkg::CODE_W-1:0];
        pocs_pkg::REG_HOP:        cfg_r.window_hop       <= wr_data[pocs_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/pocs_seq_core.sv =====
module pocs_seq_core #(
  parameter int RING_DEPTH = 512
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_en,
  input  logic                         cmd,
  input  logic [pocs_pkg::LEVEL_W-1:0] ir_sample,
  input  pocs_pkg::cfg_t               cfg,
  output pocs_pkg::res_t               res
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int EXT_W = (IDX_W > pocs_pkg::OUT_W) ? IDX_W : pocs_pkg::OUT_W;
  localparam int CNT_W = pocs_pkg::CNT_W;

  pocs_pkg::phase_t  phase_r, phase_nxt;
  logic              finger_r, finger_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic [pocs_pkg::CODE_W-1:0] hop_eff;
  logic [CNT_W-1:0]            win_len;
  logic [IDX_W:0]              tail_sum;
  logic [IDX_W-1:0]            tail_adv;
  logic [EXT_W-1:0]            slot_ext;
  logic [EXT_W-1:0]            start_ext;

  // A hop of zero behaves as a hop of one.
  assign hop_eff  = (cfg.window_hop == '0) ? pocs_pkg::CODE_W'(1) : cfg.window_hop;
  assign win_len  = CNT_W'(RING_DEPTH) - CNT_W'(hop_eff);
  assign tail_sum = (IDX_W+1)'(tail_r) + (IDX_W+1)'(hop_eff);
  assign tail_adv = (tail_sum >= (IDX_W+1)'(RING_DEPTH))
                  ? IDX_W'(tail_sum - (IDX_W+1)'(RING_DEPTH))
                  : tail_sum[IDX_W-1:0];
  assign slot_ext  = EXT_W'(head_r);
  assign start_ext = EXT_W'(tail_r);

  always_comb begin
    phase_nxt  = phase_r;
    finger_nxt = finger_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;

    res = '0;

    if (!cmd) begin
      if (finger_r) begin
        if (ir_sample < cfg.finger_off_level) begin
          finger_nxt = 1'b0;
        end
      end else if (ir_sample > cfg.finger_on_level) begin
        finger_nxt = 1'b1;
      end
      res.store_en   = 1'b1;
      res.write_slot = slot_ext[pocs_pkg::OUT_W-1:0];
      head_nxt = (head_r == IDX_W'(RING_DEPTH - 1)) ? '0 : head_r + IDX_W'(1);
      if (count_r < pocs_pkg::COUNT_MAX) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (phase_r == pocs_pkg::PH_IDLE) begin
      if (finger_r) begin
        count_nxt       = '0;
        tail_nxt        = head_r;
        res.led_cmd     = pocs_pkg::LED_HIGH;
        res.red_current = cfg.red_current_high;
        res.ir_current  = cfg.ir_current_high;
        phase_nxt       = pocs_pkg::PH_CAL;
      end
    end else if (!finger_r) begin
      res.led_cmd     = pocs_pkg::LED_LOW;
      res.red_current = cfg.red_current_low;
      res.ir_current  = cfg.ir_current_low;
      phase_nxt       = pocs_pkg::PH_IDLE;
    end else begin
      unique case (phase_r)
        pocs_pkg::PH_CAL: begin
          if (count_r > win_len) begin
            phase_nxt = pocs_pkg::PH_COMPUTE;
          end
        end
        pocs_pkg::PH_COMPUTE: begin
          res.window_go     = 1'b1;
          res.window_start  = start_ext[pocs_pkg::OUT_W-1:0];
          res.window_length = win_len[pocs_pkg::OUT_W-1:0];
          tail_nxt          = tail_adv;
          count_nxt         = '0;
          phase_nxt         = pocs_pkg::PH_COLLECT;
        end
        pocs_pkg::PH_COLLECT: begin
          if (count_r > CNT_W'(hop_eff)) begin
            phase_nxt = pocs_pkg::PH_COMPUTE;
          end
        end
        default: phase_nxt = pocs_pkg::PH_IDLE;
      endcase
    end

    res.finger_on = finger_nxt;
    res.phase     = pocs_pkg::phase_code(phase_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= pocs_pkg::PH_IDLE;
      finger_r <= 1'b0;
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      finger_r <= finger_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
    end
  end

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= IDX_W'(RING_DEPTH - 1))
    else $error("head index left the ring");

  a_tail_range: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= IDX_W'(RING_DEPTH - 1))
    else $error("tail index left the ring");

  a_sample_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && !cmd |=> phase_r == $past(phase_r))
    else $error("a sample changed the sequencer phase");

  a_window_in_collect: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.window_go |=> phase_r == pocs_pkg::PH_COLLECT && count_r == '0)
    else $error("window request did not lead to collect");

endmodule

// ===== hw/rtl/pulse_oximeter_capture_sequencer_core.sv =====
// Path: an accepted input beat is held in the input register, steps the core into the
// result register once that register is free, and is offered there until it is taken.
// Throughput: one input beat per cycle while the result channel is not stalled;
// the input register still takes one more beat while a stalled result waits.
// Reset (rst_n low at a clock edge, synchronous): both stages empty, sequencer idle,
// no finger, head, tail and sample count zero, configuration at its defaults.
module pulse_oximeter_capture_sequencer_core #(
  parameter int RING_DEPTH = 512
) (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_cmd,
  input  logic [pocs_pkg::LEVEL_W-1:0]       in_ir_sample,

  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_finger_on,
  output logic                               out_store_en,
  output logic [pocs_pkg::OUT_W-1:0]         out_write_slot,
  output logic [1:0]                         out_phase,
  output logic [1:0]                         out_led_cmd,
  output logic [pocs_pkg::CODE_W-1:0]        out_red_current,
  output logic [pocs_pkg::CODE_W-1:0]        out_ir_current,
  output logic                               out_window_go,
  output logic [pocs_pkg::OUT_W-1:0]         out_window_start,
  output logic [pocs_pkg::OUT_W-1:0]         out_window_length,

  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pocs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pocs_pkg::LEVEL_W-1:0]       cfg_data
);

  pocs_pkg::cfg_t cfg;
  pocs_pkg::res_t res;

  // Input register: holds one accepted beat until the core can take it.
  logic                         s1_valid_r;
  logic                         s1_cmd_r;
  logic [pocs_pkg::LEVEL_W-1:0] s1_ir_r;

  // Result register.
  logic                         out_valid_r;
  pocs_pkg::res_t               out_r;

  logic out_free;
  logic step_en;
  logic in_take;

  // Taken unchecked: the user must send configuration writes only while the block is quiet.
  assign cfg_ready = 1'b1;

  pocs_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The result register is free when empty or being emptied this cycle.
  assign out_free = !out_valid_r || !out_stall;
  // The core steps whenever a held beat can move on into the result register.
  assign step_en  = s1_valid_r && out_free;
  // The input register only blocks when it is full and cannot drain.
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  pocs_seq_core #(
    .RING_DEPTH (RING_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .cmd       (s1_cmd_r),
    .ir_sample (s1_ir_r),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (step_en) begin
        s1_valid_r <= 1'b0;
      end
      if (step_en) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r <= in_cmd;
      s1_ir_r  <= in_ir_sample;
    end
    if (step_en) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_finger_on     = out_r.finger_on;
  assign out_store_en      = out_r.store_en;
  assign out_write_slot    = out_r.write_slot;
  assign out_phase         = out_r.phase;
  assign out_led_cmd       = out_r.led_cmd;
  assign out_red_current   = out_r.red_current;
  assign out_ir_current    = out_r.ir_current;
  assign out_window_go     = out_r.window_go;
  assign out_window_start  = out_r.window_start;
  assign out_window_length = out_r.window_length;

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !step_en |=> s1_valid_r)
    else $error("held input beat vanished without stepping the core");

  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_valid_r)
    else $error("core step did not fill the result register");

  a_sample_no_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_store_en |-> out_led_cmd == pocs_pkg::LED_NONE && !out_window_go)
    else $error("sample result carried a sequencer command");

endmodule

// ===== sim/pocs_tb_pkg.sv =====
`timescale 1ns / 1ps
package pocs_tb_pkg;

  // Item kinds on the input channel.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // The index field has one code past the last register; writes to it are dropped.
  localparam logic [pocs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

endpackage

// ===== sim/pocs_sequencer_checker.sv =====
`timescale 1ns / 1ps
module pocs_sequencer_checker #(
  parameter int RING_DEPTH = 512
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           in_cmd,
  input  logic [pocs_pkg::LEVEL_W-1:0]   in_ir_sample,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_finger_on,
  input  logic                           out_store_en,
  input  logic [pocs_pkg::OUT_W-1:0]     out_write_slot,
  input  logic [1:0]                     out_phase,
  input  logic [1:0]                     out_led_cmd,
  input  logic [pocs_pkg::CODE_W-1:0]    out_red_current,
  input  logic [pocs_pkg::CODE_W-1:0]    out_ir_current,
  input  logic                           out_window_go,
  input  logic [pocs_pkg::OUT_W-1:0]     out_window_start,
  input  logic [pocs_pkg::OUT_W-1:0]     out_window_length,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [pocs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pocs_pkg::LEVEL_W-1:0]   cfg_data,
  output int                             fail_count,
  output int                             outstanding,
  output int                             windows_seen
);

  pocs_pkg::cfg_t        regs;
  logic [1:0]            seq_phase;
  logic                  finger;
  int unsigned           head;
  int unsigned           tail;
  int unsigned           sample_count;
  pocs_pkg::res_t        predicted_results[$];

  // Advances the private copy of the sequencer by one beat and returns the result it implies.
  function automatic pocs_pkg::res_t sequence_beat(input logic cmd,
                                                   input logic [pocs_pkg::LEVEL_W-1:0] ir);
    pocs_pkg::res_t r;
    int unsigned    hop;
    r = '0;
    hop = (regs.window_hop == '0) ? 32'd1 : 32'(regs.window_hop);
    if (cmd == pocs_tb_pkg::CMD_SAMPLE) begin
      if (finger) begin
        if (ir < regs.finger_off_level) finger = 1'b0;
      end else if (ir > regs.finger_on_level) begin
        finger = 1'b1;
      end
      r.store_en = 1'b1;
      r.write_slot = head[pocs_pkg::OUT_W-1:0];
      head = (head + 1 >= RING_DEPTH) ? 0 : head + 1;
      if (sample_count < pocs_pkg::COUNT_MAX) sample_count++;
    end else if (seq_phase == pocs_pkg::PHASE_CODE_IDLE) begin
      if (finger) begin
        sample_count = 0;
        tail = head;
        r.led_cmd = pocs_pkg::LED_HIGH;
        r.red_current = regs.red_current_high;
        r.ir_current = regs.ir_current_high;
        seq_phase = pocs_pkg::PHASE_CODE_CAL;
      end
    end else if (!finger) begin
      r.led_cmd = pocs_pkg::LED_LOW;
      r.red_current = regs.red_current_low;
      r.ir_current = regs.ir_current_low;
      seq_phase = pocs_pkg::PHASE_CODE_IDLE;
    end else if (seq_phase == pocs_pkg::PHASE_CODE_CAL) begin
      if (sample_count > RING_DEPTH - hop) seq_phase = pocs_pkg::PHASE_CODE_COMPUTE;
    end else if (seq_phase == pocs_pkg::PHASE_CODE_COMPUTE) begin
      r.window_go = 1'b1;
      r.window_start = tail[pocs_pkg::OUT_W-1:0];
      r.window_length = pocs_pkg::OUT_W'(RING_DEPTH - hop);
      tail = (tail + hop >= RING_DEPTH) ? tail + hop - RING_DEPTH : tail + hop;
      sample_count = 0;
      seq_phase = pocs_pkg::PHASE_CODE_COLLECT;
    end else begin
      if (sample_count > hop) seq_phase = pocs_pkg::PHASE_CODE_COMPUTE;
    end
    r.finger_on = finger;
    r.phase = seq_phase;
    return r;
  endfunction

  function automatic void compare_field(input string field, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    pocs_pkg::res_t want;
    if (!rst_n) begin
      regs.finger_on_level = 18'd50000;
      regs.finger_off_level = 18'd30000;
      regs.red_current_high = 8'd36;
      regs.ir_current_high = 8'd36;
      regs.red_current_low = 8'd2;
      regs.ir_current_low = 8'd2;
      regs.window_hop = 8'd100;
      seq_phase = pocs_pkg::PHASE_CODE_IDLE;
      finger = 1'b0;
      head = 0;
      tail = 0;
      sample_count = 0;
      predicted_results.delete();
      fail_count = 0;
      windows_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pocs_pkg::REG_FINGER_ON:  regs.finger_on_level = cfg_data;
          pocs_pkg::REG_FINGER_OFF: regs.finger_off_level = cfg_data;
          pocs_pkg::REG_RED_HIGH:   regs.red_current_high = cfg_data[pocs_pkg::CODE_W-1:0];
          pocs_pkg::REG_IR_HIGH:    regs.ir_current_high = cfg_data[pocs_pkg::CODE_W-1:0];
          pocs_pkg::REG_RED_LOW:    regs.red_current_low = cfg_data[pocs_pkg::CODE_W-1:0];
          pocs_pkg::REG_IR_LOW:     regs.ir_current_low = cfg_data[pocs_pkg::CODE_W-1:0];
          pocs_pkg::REG_HOP:        regs.window_hop = cfg_data[pocs_pkg::CODE_W-1:0];
          default:                  ;
        endcase
      end
      if (in_valid && !in_stall) predicted_results.push_back(sequence_beat(in_cmd, in_ir_sample));
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $display("%0t ns: result beat arrived with nothing expected", $time);
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          compare_field("finger_on", want.finger_on, out_finger_on);
          compare_field("store_en", want.store_en, out_store_en);
          compare_field("write_slot", want.write_slot, out_write_slot);
          compare_field("phase", want.phase, out_phase);
          compare_field("led_cmd", want.led_cmd, out_led_cmd);
          compare_field("red_current", want.red_current, out_red_current);
          compare_field("ir_current", want.ir_current, out_ir_current);
          compare_field("window_go", want.window_go, out_window_go);
          compare_field("window_start", want.window_start, out_window_start);
          compare_field("window_length", want.window_length, out_window_length);
          if (want.window_go) windows_seen++;
        end
      end
    end
    outstanding = predicted_results.size();
  end

endmodule

// ===== sim/pulse_oximeter_capture_sequencer_core_test.sv =====
`timescale 1ns / 1ps
module pulse_oximeter_capture_sequencer_core_test;

  localparam int RING_DEPTH = 512;
  // Far beyond the slowest legal run, even with every beat hit by the longest gap and stall.
  localparam int CYCLE_LIMIT = 3_000_000;
  // Drain allowance past the input and result registers of the block, with some margin.
  localparam int DRAIN_CYCLES = 8;
  // Exactly enough samples in calibrate for a hop of one to move on to compute, and one
  // short of what a hop of zero would need.
  localparam int CAL_RUN = 512;
  localparam logic [pocs_pkg::LEVEL_W-1:0] LEVEL_MAX = '1;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic                           in_cmd;
  logic [pocs_pkg::LEVEL_W-1:0]   in_ir_sample;
  logic                           out_valid;
  logic                           out_stall;
  logic                           out_finger_on;
  logic                           out_store_en;
  logic [pocs_pkg::OUT_W-1:0]     out_write_slot;
  logic [1:0]                     out_phase;
  logic [1:0]                     out_led_cmd;
  logic [pocs_pkg::CODE_W-1:0]    out_red_current;
  logic [pocs_pkg::CODE_W-1:0]    out_ir_current;
  logic                           out_window_go;
  logic [pocs_pkg::OUT_W-1:0]     out_window_start;
  logic [pocs_pkg::OUT_W-1:0]     out_window_length;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [pocs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pocs_pkg::LEVEL_W-1:0]   cfg_data;

  int fail_count;
  int outstanding;
  int windows_seen;
  int cycles = 0;
  int samples_sent = 0;
  int ticks_sent = 0;
  int settings_used = 0;

  // Idling switches, flipped now and then so that some stretches run flat out.
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  // The thresholds currently programmed, so that IR readings can be aimed at them.
  int unsigned cur_on = 50000;
  int unsigned cur_off = 30000;

  pulse_oximeter_capture_sequencer_core #(.RING_DEPTH(RING_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_ir_sample(in_ir_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_finger_on(out_finger_on),
    .out_store_en(out_store_en), .out_write_slot(out_write_slot), .out_phase(out_phase),
    .out_led_cmd(out_led_cmd), .out_red_current(out_red_current),
    .out_ir_current(out_ir_current), .out_window_go(out_window_go),
    .out_window_start(out_window_start), .out_window_length(out_window_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // The checker sits beside the block, watches all three channels and keeps the score.
  pocs_sequencer_checker #(.RING_DEPTH(RING_DEPTH)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_ir_sample(in_ir_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_finger_on(out_finger_on),
    .out_store_en(out_store_en), .out_write_slot(out_write_slot), .out_phase(out_phase),
    .out_led_cmd(out_led_cmd), .out_red_current(out_red_current),
    .out_ir_current(out_ir_current), .out_window_go(out_window_go),
    .out_window_start(out_window_start), .out_window_length(out_window_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .outstanding(outstanding), .windows_seen(windows_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure rather than spinning forever.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles without finishing.", CYCLE_LIMIT);
      $display("pulse_oximeter_capture_sequencer_core: mismatch");
      $finish;
    end
  end

  // Idle stretches are mostly short, with the occasional long one.
  function automatic int idle_length();
    if ($urandom_range(0, 15) == 0) return $urandom_range(8, 24);
    return $urandom_range(0, 3);
  endfunction

  // Back-pressure on the result channel. The stall level is only ever changed at the
  // falling edge, and once raised it is held for a whole run of cycles.
  initial begin : stall_driver
    int run;
    run = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (run == 0) begin
        out_stall = stalls_on && ($urandom_range(0, 3) == 0);
        run = out_stall ? idle_length() : 0;
      end else begin
        run--;
      end
    end
  end

  // Offers one beat after an optional gap and returns once the block has taken it.
  // Valid stays high after acceptance until the next falling edge decides what comes next,
  // so back-to-back beats never see valid dropped and raised within one time step.
  task automatic send_beat(input logic cmd, input logic [pocs_pkg::LEVEL_W-1:0] ir);
    int gap;
    gap = (gaps_on && $urandom_range(0, 2) == 0) ? idle_length() + 1 : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_cmd = cmd;
    in_ir_sample = ir;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == pocs_tb_pkg::CMD_TICK) ticks_sent++;
    else samples_sent++;
  endtask

  // Stops offering beats and waits until every predicted result has been seen, then lets
  // the pipeline drain a little further before anything else happens.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [pocs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pocs_pkg::LEVEL_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Programs every register. The eight-bit registers get random junk in the unused upper
  // bits of the data word, which the block must ignore.
  task automatic apply_setting(input int unsigned on_level, input int unsigned off_level,
                               input logic [pocs_pkg::CODE_W-1:0] red_hi,
                               input logic [pocs_pkg::CODE_W-1:0] ir_hi,
                               input logic [pocs_pkg::CODE_W-1:0] red_lo,
                               input logic [pocs_pkg::CODE_W-1:0] ir_lo,
                               input logic [pocs_pkg::CODE_W-1:0] hop);
    settle();
    write_reg(pocs_pkg::REG_FINGER_ON, pocs_pkg::LEVEL_W'(on_level));
    write_reg(pocs_pkg::REG_FINGER_OFF, pocs_pkg::LEVEL_W'(off_level));
    write_reg(pocs_pkg::REG_RED_HIGH, {10'($urandom), red_hi});
    write_reg(pocs_pkg::REG_IR_HIGH, {10'($urandom), ir_hi});
    write_reg(pocs_pkg::REG_RED_LOW, {10'($urandom), red_lo});
    write_reg(pocs_pkg::REG_IR_LOW, {10'($urandom), ir_lo});
    write_reg(pocs_pkg::REG_HOP, {10'($urandom), hop});
    cur_on = pocs_pkg::LEVEL_W'(on_level);
    cur_off = pocs_pkg::LEVEL_W'(off_level);
    settings_used++;
  endtask

  // A random LED code.
  function automatic logic [pocs_pkg::CODE_W-1:0] any_code();
    return pocs_pkg::CODE_W'($urandom);
  endfunction

  // An IR reading that keeps a finger in place or away from the sensor, as asked.
  // A small share lands on the thresholds themselves or anywhere at all.
  function automatic logic [pocs_pkg::LEVEL_W-1:0] pick_ir(input bit present);
    case ($urandom_range(0, 15))
      0: return pocs_pkg::LEVEL_W'($urandom);
      1: begin
        case ($urandom_range(0, 5))
          0: return '0;
          1: return LEVEL_MAX;
          2: return pocs_pkg::LEVEL_W'(cur_on);
          3: return pocs_pkg::LEVEL_W'(cur_on + 1);
          4: return pocs_pkg::LEVEL_W'(cur_off);
          default: return pocs_pkg::LEVEL_W'(cur_off - 1);
        endcase
      end
      default: begin
        if (present) begin
          return (cur_on < LEVEL_MAX)
                 ? pocs_pkg::LEVEL_W'($urandom_range(cur_on + 1, LEVEL_MAX)) : LEVEL_MAX;
        end
        return (cur_off > 0) ? pocs_pkg::LEVEL_W'($urandom_range(0, cur_off - 1)) : '0;
      end
    endcase
  endfunction

  // Random traffic shaped like real use: long runs with a finger on the sensor and a tick
  // every so often, so that the sequencer climbs through calibrate, compute and collect.
  // The finger is lifted only rarely, and the idling switches flip now and then.
  task automatic run_random(input int count);
    bit present;
    int k;
    present = 1'b1;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 399) == 0) present = !present;
      if ($urandom_range(0, 99) == 0) gaps_on = !gaps_on;
      if ($urandom_range(0, 99) == 0) stalls_on = !stalls_on;
      if ($urandom_range(0, 7) == 0) begin
        send_beat(pocs_tb_pkg::CMD_TICK, pocs_pkg::LEVEL_W'($urandom));
      end else begin
        send_beat(pocs_tb_pkg::CMD_SAMPLE, pick_ir(present));
      end
    end
  endtask

  initial begin : stimulus
    int k;
    int unsigned lvl_a;
    int unsigned lvl_b;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = pocs_tb_pkg::CMD_SAMPLE;
    in_ir_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = pocs_pkg::REG_FINGER_ON;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset configuration. An idle tick with no finger does nothing;
    // readings exactly on a threshold must not flip the flag, one step past it must.
    send_beat(pocs_tb_pkg::CMD_TICK, '0);
    send_beat(pocs_tb_pkg::CMD_SAMPLE, '0);
    send_beat(pocs_tb_pkg::CMD_SAMPLE, pocs_pkg::LEVEL_W'(cur_on));
    send_beat(pocs_tb_pkg::CMD_SAMPLE, pocs_pkg::LEVEL_W'(cur_on + 1));
    send_beat(pocs_tb_pkg::CMD_SAMPLE, LEVEL_MAX);
    // Finger present: the idle tick commands the high currents and enters calibrate,
    // and a second tick stays there since hardly any samples have arrived.
    send_beat(pocs_tb_pkg::CMD_TICK, LEVEL_MAX);
    send_beat(pocs_tb_pkg::CMD_TICK, '0);
    send_beat(pocs_tb_pkg::CMD_SAMPLE, pocs_pkg::LEVEL_W'(cur_off));
    send_beat(pocs_tb_pkg::CMD_SAMPLE, pocs_pkg::LEVEL_W'(cur_off - 1));
    // Finger gone: the tick falls back to idle with the low currents.
    send_beat(pocs_tb_pkg::CMD_TICK, '0);
    send_beat(pocs_tb_pkg::CMD_TICK, '0);
    send_beat(pocs_tb_pkg::CMD_SAMPLE, LEVEL_MAX);
    send_beat(pocs_tb_pkg::CMD_TICK, '0);
    send_beat(pocs_tb_pkg::CMD_SAMPLE, '0);
    send_beat(pocs_tb_pkg::CMD_TICK, LEVEL_MAX);

    // A write to the spare index must leave every register alone.
    settle();
    write_reg(pocs_tb_pkg::REG_UNUSED, pocs_pkg::LEVEL_W'($urandom));

    // Zero hop counts as a hop of one. A full ring of samples in calibrate wraps the head
    // index and leaves the count one above the window length, so the next tick moves on to
    // compute only if the hop was taken as one.
    apply_setting(1000, 500, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'd0);
    send_beat(pocs_tb_pkg::CMD_SAMPLE, LEVEL_MAX);
    send_beat(pocs_tb_pkg::CMD_TICK, '0);
    gaps_on = 1'b0;
    for (k = 0; k < CAL_RUN; k++) begin
      send_beat(pocs_tb_pkg::CMD_SAMPLE, pocs_pkg::LEVEL_W'($urandom_range(2000, LEVEL_MAX)));
    end
    gaps_on = 1'b1;
    send_beat(pocs_tb_pkg::CMD_TICK, '0);
    send_beat(pocs_tb_pkg::CMD_TICK, '0);
    send_beat(pocs_tb_pkg::CMD_SAMPLE, LEVEL_MAX);
    send_beat(pocs_tb_pkg::CMD_SAMPLE, LEVEL_MAX);
    send_beat(pocs_tb_pkg::CMD_TICK, '0);
    send_beat(pocs_tb_pkg::CMD_TICK, '0);

    // Random part, over a series of settings. The sequencer state carries across them,
    // so a wide hop first gets through calibrate quickly and small hops then produce
    // windows at a high rate.
    apply_setting(50000, 30000, 8'd36, 8'd36, 8'd2, 8'd2, 8'd255);
    run_random(160);
    apply_setting(40000, 20000, 8'd0, 8'd255, 8'd255, 8'd0, 8'd3);
    run_random(130);
    apply_setting(0, 0, any_code(), any_code(), any_code(), any_code(), 8'd0);
    run_random(80);
    apply_setting(LEVEL_MAX, LEVEL_MAX, any_code(), any_code(), any_code(), any_code(), 8'd1);
    run_random(60);
    lvl_a = $urandom_range(0, LEVEL_MAX);
    lvl_b = $urandom_range(0, LEVEL_MAX);
    apply_setting((lvl_a > lvl_b) ? lvl_a : lvl_b, (lvl_a > lvl_b) ? lvl_b : lvl_a,
                  any_code(), any_code(), any_code(), any_code(),
                  pocs_pkg::CODE_W'($urandom_range(1, 255)));
    run_random(100);
    apply_setting(60000, 60000, any_code(), any_code(), any_code(), any_code(), 8'd128);
    run_random(100);

    settle();
    $display("Covered %0d sample beats and %0d tick beats across %0d register settings.",
             samples_sent, ticks_sent, settings_used);
    $display("The sequencer requested %0d analysis windows along the way.", windows_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("pulse_oximeter_capture_sequencer_core: match");
    end else begin
      $display("pulse_oximeter_capture_sequencer_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pocs_pkg.sv
hw/rtl/pocs_cfg_regs.sv
hw/rtl/pocs_seq_core.sv
hw/rtl/pulse_oximeter_capture_sequencer_core.sv
sim/pocs_tb_pkg.sv
sim/pocs_sequencer_checker.sv
sim/pulse_oximeter_capture_sequencer_core_test.sv
